// ===== rtl/core/mslcg_pkg.sv =====
// Package: command codes, modulus constants and modular helpers for the LCG.
package mslcg_pkg;

    typedef enum logic [2:0] {
        CMD_NEXT    = 3'd0,
        CMD_SEED    = 3'd1,
        CMD_RANGED  = 3'd2,
        CMD_RESTORE = 3'd3,
        CMD_READ    = 3'd4
    } cmd_t;

    localparam logic [30:0] LCG_MOD     = 31'h7FFF_FFFF;
    localparam logic [14:0] LCG_MULT    = 15'd16807;
    localparam logic [31:0] SEED_OFFSET = 32'd2;
    localparam logic [30:0] RESET_STATE = 31'd1;

    // p mod (2^31-1) by end-around fold; valid for p < 2^47, returns 0..M
    function automatic logic [30:0] lcg_fold(input logic [46:0] p);
        logic [31:0] s;
        s = {1'b0, p[30:0]} + {16'b0, p[46:31]};
        if (s > {1'b0, LCG_MOD})
            s = s - {1'b0, LCG_MOD};
        return s[30:0];
    endfunction

    // one generator step; a zero residue maps to M
    function automatic logic [30:0] lcg_advance(input logic [30:0] s);
        logic [46:0] p;
        logic [30:0] r;
        p = 47'(s) * 47'(LCG_MULT);
        r = lcg_fold(p);
        return (r == '0) ? LCG_MOD : r;
    endfunction

    // 16807^steps mod M, evaluated at elaboration
    function automatic logic [30:0] lcg_warm_mult(input int unsigned steps);
        longint unsigned acc;
        acc = 64'd1;
        for (int unsigned i = 0; i < steps; i++)
            acc = (acc * 64'(LCG_MULT)) % 64'(LCG_MOD);
        return acc[30:0];
    endfunction

endpackage

// ===== rtl/core/minimal_standard_lcg_generator_top.sv =====
// Top level: Park-Miller minimal standard generator with seed and range mapping.
//
// Usage:
//   Requests enter on the s_* stream: s_tuser carries the command (next, seed,
//   ranged, restore, read), s_tdata the operands. Every request yields exactly
//   one response on the m_* stream: raw state after the command plus the
//   range-mapped value (zero unless the command was ranged).
//   Throughput: one request per cycle, every command, unless m_tready stalls
//   the output. The state loop (one 31x15 constant multiply plus end-around
//   fold) closes in a single stage; seeding multiplies by the precomputed
//   constant 16807^WARMUP_STEPS, split into 15-bit high and 16-bit low halves
//   one stage ahead of the state stage, so it does not touch the loop.
//   Range mapping is a 32x32 multiply followed by an exact divide by 2^31-1
//   built from a fold and small compares, spread over three stages.
//   Reset: state returns to 1, pipeline empties, no response is pending.
//   Stall: each stage holds when the one after it is full and blocked, so
//   bubbles close up; s_tready drops only when all six stages hold requests.
module minimal_standard_lcg_generator_top
    import mslcg_pkg::*;
#(
    parameter int unsigned WARMUP_STEPS = 51
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // seed_value[31:0], restore_value[30:0],
                                    // range_low[30:0], range_high[30:0], zero pad
    input  logic [2:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata    // raw_value[30:0], mapped_value[31:0], zero pad
);

    localparam logic [30:0] WARM_MULT = lcg_warm_mult(WARMUP_STEPS);
    localparam logic [14:0] WARM_HI   = WARM_MULT[30:16];
    localparam logic [15:0] WARM_LO   = WARM_MULT[15:0];
    localparam bit          WARM_ON   = (WARMUP_STEPS != 0);

    localparam logic signed [33:0] V_MOD     = $signed({3'b0, LCG_MOD});
    localparam logic signed [33:0] V_NEG_MOD = -V_MOD;
    localparam logic signed [33:0] V_2MOD    = V_MOD + V_MOD;
    localparam logic signed [33:0] V_NEG_2MOD = -V_2MOD;

    localparam int NSTAGE = 6;

    // ---------------- stage control ----------------
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] ld;      // stage may load this cycle

    always_comb
    begin
        ld[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_tready;
        for (int i = NSTAGE - 2; i >= 0; i--)
            ld[i] = !vld_reg[i] || ld[i+1];
    end

    assign s_tready = ld[0];
    assign m_tvalid = vld_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
                vld_reg[0] <= s_tvalid;
            for (int i = 1; i < NSTAGE; i++)
                if (ld[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // ---------------- stage 0: request register ----------------
    logic [2:0]         st0_cmd_reg;
    logic signed [31:0] st0_seed_reg;
    logic [30:0]        st0_restore_reg;
    logic signed [30:0] st0_lo_reg;
    logic signed [30:0] st0_hi_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0] && s_tvalid)
        begin
            st0_cmd_reg     <= s_tuser;
            st0_seed_reg    <= $signed(s_tdata[31:0]);
            st0_restore_reg <= s_tdata[62:32];
            st0_lo_reg      <= $signed(s_tdata[93:63]);
            st0_hi_reg      <= $signed(s_tdata[124:94]);
        end
    end

    // ---------------- stage 1: seed partial products, range span ----------------
    logic [31:0]        seed_bits;
    logic [31:0]        seed_mag;
    logic [31:0]        seed_sum;
    logic [30:0]        seed_x;
    logic [30:0]        st1_r1_next, st1_r0_next;
    logic signed [31:0] st1_d_next;

    logic [2:0]         st1_cmd_reg;
    logic [30:0]        st1_r1_reg, st1_r0_reg;
    logic [30:0]        st1_restore_reg;
    logic signed [30:0] st1_lo_reg;
    logic signed [31:0] st1_d_reg;

    always_comb
    begin
        seed_bits   = st0_seed_reg;
        seed_mag    = seed_bits[31] ? (32'd0 - seed_bits) : seed_bits;
        seed_sum    = seed_mag + SEED_OFFSET;
        seed_x      = seed_sum[30:0];           // wraps to 31 bits
        st1_r1_next = lcg_fold(47'(seed_x) * 47'(WARM_HI));
        st1_r0_next = lcg_fold(47'(seed_x) * 47'(WARM_LO));
        st1_d_next  = $signed({st0_hi_reg[30], st0_hi_reg})
                    - $signed({st0_lo_reg[30], st0_lo_reg});
    end

    always_ff @(posedge clk)
    begin
        if (ld[1] && vld_reg[0])
        begin
            st1_cmd_reg     <= st0_cmd_reg;
            st1_r1_reg      <= st1_r1_next;
            st1_r0_reg      <= st1_r0_next;
            st1_restore_reg <= st0_restore_reg;
            st1_lo_reg      <= st0_lo_reg;
            st1_d_reg       <= st1_d_next;
        end
    end

    // ---------------- stage 2: generator state update ----------------
    logic [30:0] state_reg;
    logic [30:0] state_next;
    logic [30:0] seed_rot;
    logic [31:0] seed_acc;
    logic [31:0] seed_red;
    logic [30:0] seed_state;

    logic [30:0]        st2_raw_reg;
    logic signed [30:0] st2_lo_reg;
    logic signed [31:0] st2_d_reg;
    logic               st2_rng_reg;

    always_comb
    begin
        // high partial times 2^16 mod M is a 31-bit rotate
        seed_rot   = {st1_r1_reg[14:0], st1_r1_reg[30:15]};
        seed_acc   = {1'b0, seed_rot} + {1'b0, st1_r0_reg};
        seed_red   = (seed_acc > {1'b0, LCG_MOD}) ? (seed_acc - {1'b0, LCG_MOD}) : seed_acc;
        seed_state = (WARM_ON && seed_red[30:0] == '0) ? LCG_MOD : seed_red[30:0];

        unique case (st1_cmd_reg) inside
            CMD_NEXT, CMD_RANGED: state_next = lcg_advance(state_reg);
            CMD_SEED:             state_next = seed_state;
            CMD_RESTORE:          state_next = st1_restore_reg;
            default:              state_next = state_reg;   // read, unused codes
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= RESET_STATE;
        else if (ld[2] && vld_reg[1])
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (ld[2] && vld_reg[1])
        begin
            st2_raw_reg <= state_next;
            st2_lo_reg  <= st1_lo_reg;
            st2_d_reg   <= st1_d_reg;
            st2_rng_reg <= (st1_cmd_reg == CMD_RANGED);
        end
    end

    // ---------------- stage 3: span times state ----------------
    logic signed [63:0] prod;
    logic signed [62:0] st3_p_reg;
    logic [30:0]        st3_raw_reg;
    logic signed [30:0] st3_lo_reg;
    logic               st3_rng_reg;

    always_comb
    begin
        prod = 64'(st2_d_reg) * 64'($signed({1'b0, st2_raw_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (ld[3] && vld_reg[2])
        begin
            st3_p_reg   <= $signed(prod[62:0]);
            st3_raw_reg <= st2_raw_reg;
            st3_lo_reg  <= st2_lo_reg;
            st3_rng_reg <= st2_rng_reg;
        end
    end

    // ---------------- stage 4: fold product, floor quotient digit ----------------
    // P = hi*2^31 + lo = hi*M + (hi + lo), so floor(P/M) = hi + floor((hi+lo)/M)
    logic [31:0]        p_hi;
    logic signed [33:0] v2;
    logic signed [2:0]  k_next;

    logic [31:0]        st4_hi_reg;
    logic signed [33:0] st4_v2_reg;
    logic signed [2:0]  st4_k_reg;
    logic [30:0]        st4_raw_reg;
    logic signed [30:0] st4_lo_reg;
    logic               st4_rng_reg;

    always_comb
    begin
        p_hi = st3_p_reg[62:31];
        v2   = $signed({{2{p_hi[31]}}, p_hi} + {3'b0, st3_p_reg[30:0]});
        if (v2 < V_NEG_MOD)
            k_next = -3'sd2;
        else if (v2 < 34'sd0)
            k_next = -3'sd1;
        else if (v2 < V_MOD)
            k_next = 3'sd0;
        else if (v2 < V_2MOD)
            k_next = 3'sd1;
        else
            k_next = 3'sd2;
    end

    always_ff @(posedge clk)
    begin
        if (ld[4] && vld_reg[3])
        begin
            st4_hi_reg  <= p_hi;
            st4_v2_reg  <= v2;
            st4_k_reg   <= k_next;
            st4_raw_reg <= st3_raw_reg;
            st4_lo_reg  <= st3_lo_reg;
            st4_rng_reg <= st3_rng_reg;
        end
    end

    // ---------------- stage 5: truncate toward zero, result register ----------------
    logic signed [33:0] k_mod;
    logic [33:0]        base;
    logic [33:0]        mapped_full;
    logic               rem_nz;

    logic [30:0]        st5_raw_reg;
    logic [31:0]        st5_mapped_reg;

    always_comb
    begin
        case (st4_k_reg)
            -3'sd2:  k_mod = V_NEG_2MOD;
            -3'sd1:  k_mod = V_NEG_MOD;
            3'sd1:   k_mod = V_MOD;
            3'sd2:   k_mod = V_2MOD;
            default: k_mod = 34'sd0;
        endcase
        rem_nz = (st4_v2_reg != k_mod);
        base   = {{3{st4_lo_reg[30]}}, st4_lo_reg}
               + {{2{st4_hi_reg[31]}}, st4_hi_reg}
               + {{31{st4_k_reg[2]}}, st4_k_reg};
        // negative quotient with a remainder rounds up toward zero
        mapped_full = base + {33'b0, base[33] & rem_nz};
    end

    always_ff @(posedge clk)
    begin
        if (ld[5] && vld_reg[4])
        begin
            st5_raw_reg    <= st4_raw_reg;
            st5_mapped_reg <= st4_rng_reg ? mapped_full[31:0] : 32'd0;
        end
    end

    assign m_tdata = {1'b0, st5_mapped_reg, st5_raw_reg};

`ifndef SYNTHESIS
    // input side blocks only when every stage holds a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&vld_reg))
        else $error("s_tready low with a free stage");

    // requests in flight are conserved
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(vld_reg) == $countones($past(vld_reg))
                          + int'($past(s_tvalid && s_tready))
                          - int'($past(m_tvalid && m_tready))))
        else $error("request lost or duplicated in pipeline");

    // a next command never leaves a zero state
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[1] && ld[2] && st1_cmd_reg == CMD_NEXT) |=> (state_reg != '0))
        else $error("advance produced zero state");

    // read leaves the state alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[1] && ld[2] && st1_cmd_reg == CMD_READ) |=> $stable(state_reg))
        else $error("read changed the state");
`endif

endmodule

// ===== sim/minimal_standard_lcg_generator_top_tb.sv =====
// Self-checking testbench for the minimal standard LCG generator stream block.
`timescale 1ns / 1ps

module minimal_standard_lcg_generator_top_tb;
    import mslcg_pkg::*;

    localparam int unsigned SEED_WARMUP   = 51;
    localparam int          RANDOM_ITEMS  = 1075;
    localparam int          LONG_HOLD     = 60;   // receiver hold-off, well past pipeline depth
    localparam int          HOLD_SPACING  = 350;
    localparam int          DRAIN_CYCLES  = 20;

    // cmd codes the block does not define; they must act as a read
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    localparam logic signed [30:0] BOUND_MIN = 31'sh4000_0000;
    localparam logic signed [30:0] BOUND_MAX = 31'sh3FFF_FFFF;

    typedef struct {
        logic [2:0]         cmd;
        logic signed [31:0] seed;
        logic [30:0]        restore;
        logic signed [30:0] range_low;
        logic signed [30:0] range_high;
    } lcg_request_t;

    typedef struct {
        logic [2:0]         cmd;
        logic [30:0]        raw;
        logic signed [31:0] mapped;
    } lcg_response_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;   // seed_value, restore_value, range_low, range_high, pad
    logic [2:0]   s_tuser = '0;   // cmd
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;        // raw_value, mapped_value, pad

    lcg_request_t  pending_requests[$];
    lcg_response_t expected_responses[$];
    lcg_request_t  cur_request;
    logic [30:0]   gen_state = RESET_STATE;

    int  req_accepted = 0;
    int  responses_checked = 0;
    int  error_count = 0;
    int  cmd_seen[8];
    int  tx_gap = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  next_hold_at = 200;
    int  holds_done = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    minimal_standard_lcg_generator_top #(
        .WARMUP_STEPS(SEED_WARMUP)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one multiply-mod step; zero residue becomes the modulus
    function automatic logic [30:0] pm_step(input logic [30:0] s);
        longint unsigned prod;
        prod = (64'(s) * 64'(LCG_MULT)) % 64'(LCG_MOD);
        return (prod == 0) ? LCG_MOD : prod[30:0];
    endfunction

    // updates gen_state and returns the response the block should give
    function automatic lcg_response_t apply_command(input lcg_request_t r);
        lcg_response_t res;
        longint        mag;
        longint        lo;
        longint        hi;
        longint        num;
        res.cmd    = r.cmd;
        res.mapped = '0;
        case (r.cmd)
            CMD_NEXT:
                gen_state = pm_step(gen_state);
            CMD_SEED:
            begin
                mag = longint'(r.seed);
                if (mag < 0)
                    mag = -mag;
                gen_state = 31'(mag + 2);   // wraps to 31 bits for the largest seeds
                for (int i = 0; i < SEED_WARMUP; i++)
                    gen_state = pm_step(gen_state);
            end
            CMD_RANGED:
            begin
                gen_state = pm_step(gen_state);
                lo  = longint'(r.range_low);
                hi  = longint'(r.range_high);
                num = lo * longint'(LCG_MOD) + (hi - lo) * longint'(gen_state);
                res.mapped = 32'(num / longint'(LCG_MOD));   // truncates toward zero
            end
            CMD_RESTORE:
                gen_state = r.restore;
            default:
                ;   // read and spare codes leave the state alone
        endcase
        res.raw = gen_state;
        return res;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_idle(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic signed [30:0] rand_bound();
        if ($urandom_range(0, 1) == 0)
            return 31'($urandom);
        return 31'($urandom_range(0, 2000)) - 31'sd1000;
    endfunction

    task automatic queue_request(input logic [2:0] c, input logic signed [31:0] sd,
                                 input logic [30:0] rv, input logic signed [30:0] lo,
                                 input logic signed [30:0] hi);
        lcg_request_t r;
        r.cmd        = c;
        r.seed       = sd;
        r.restore    = rv;
        r.range_low  = lo;
        r.range_high = hi;
        pending_requests.push_back(r);
    endtask

    // sender: predicts each request as it is accepted, then offers the next
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        lcg_request_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            tx_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_responses.push_back(apply_command(cur_request));
                cmd_seen[cur_request.cmd]++;
                req_accepted <= req_accepted + 1;
            end
            if ($urandom_range(0, 79) == 0)
                tx_steady <= !tx_steady;
            if (!s_tvalid || s_tready)
            begin
                // keep offering while the receiver holds off so the pipe fills
                if (tx_gap != 0 && hold_left == 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    nxt         = pending_requests.pop_front();
                    cur_request = nxt;
                    s_tdata     <= {3'b000, nxt.range_high, nxt.range_low, nxt.restore, nxt.seed};
                    s_tuser     <= nxt.cmd;
                    s_tvalid    <= 1'b1;
                    tx_gap      <= pick_idle(tx_steady);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: checks responses in order and throttles m_tready
    always @(posedge clk or negedge rst_n)
    begin : response_monitor
        lcg_response_t want;
        logic [30:0]   got_raw;
        logic [31:0]   got_mapped;
        int            n;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_raw    = m_tdata[30:0];
                got_mapped = m_tdata[62:31];
                if (expected_responses.size() == 0)
                begin
                    $display("%0t: response with no request outstanding, expected none,",
                             $time);
                    $display("  got raw %0d mapped %0d", got_raw, $signed(got_mapped));
                    error_count++;
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (got_raw !== want.raw)
                    begin
                        $display("%0t: raw_value mismatch (cmd %0d), expected %0d, got %0d",
                                 $time, want.cmd, want.raw, got_raw);
                        error_count++;
                    end
                    if (got_mapped !== want.mapped)
                    begin
                        $display("%0t: mapped_value mismatch (cmd %0d), expected %0d, got %0d",
                                 $time, want.cmd, want.mapped, $signed(got_mapped));
                        error_count++;
                    end
                    responses_checked++;
                end
            end
            if ($urandom_range(0, 79) == 0)
                rx_steady <= !rx_steady;
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (req_accepted >= next_hold_at)
            begin
                hold_left    <= LONG_HOLD;
                next_hold_at <= next_hold_at + HOLD_SPACING;
                holds_done++;
                m_tready     <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                n = pick_idle(rx_steady);
                if (n == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready   <= 1'b0;
                    stall_left <= n - 1;
                end
            end
        end
    end

    initial
    begin : stimulus
        int                 r;
        int                 total_requests;
        logic [2:0]         c;
        logic signed [31:0] sd;
        logic [30:0]        rv;

        // directed: state 1 out of reset, zero residue, full state, seed extremes
        queue_request(CMD_NEXT, $urandom, 31'($urandom), rand_bound(), rand_bound());
        queue_request(CMD_READ, $urandom, 31'($urandom), rand_bound(), rand_bound());
        queue_request(CMD_RANGED, $urandom, 31'($urandom), 31'sd0, 31'sd1000);
        queue_request(CMD_RESTORE, $urandom, 31'd0, rand_bound(), rand_bound());
        queue_request(CMD_READ, $urandom, 31'($urandom), rand_bound(), rand_bound());
        queue_request(CMD_NEXT, $urandom, 31'($urandom), rand_bound(), rand_bound());
        queue_request(CMD_NEXT, $urandom, 31'($urandom), rand_bound(), rand_bound());
        queue_request(CMD_RANGED, $urandom, 31'($urandom), -31'sd5, 31'sd100);
        queue_request(CMD_RESTORE, $urandom, LCG_MOD, rand_bound(), rand_bound());
        queue_request(CMD_RANGED, $urandom, 31'($urandom), BOUND_MIN, BOUND_MAX);
        queue_request(CMD_SEED, 32'sd0, 31'($urandom), rand_bound(), rand_bound());
        queue_request(CMD_SEED, -32'sd1, 31'($urandom), rand_bound(), rand_bound());
        queue_request(CMD_SEED, 32'sh7FFF_FFFF, 31'($urandom), rand_bound(), rand_bound());
        queue_request(CMD_SEED, 32'sh8000_0000, 31'($urandom), rand_bound(), rand_bound());
        queue_request(CMD_SEED, 32'sd2147483645, 31'($urandom), rand_bound(), rand_bound());
        queue_request(CMD_SEED, -32'sd2147483645, 31'($urandom), rand_bound(), rand_bound());
        queue_request(CMD_RANGED, $urandom, 31'($urandom), BOUND_MIN, BOUND_MAX);
        queue_request(CMD_RANGED, $urandom, 31'($urandom), BOUND_MAX, BOUND_MIN);
        queue_request(CMD_RANGED, $urandom, 31'($urandom), 31'sd77, 31'sd77);
        queue_request(CMD_RESTORE, $urandom, LCG_MOD - 31'd1, rand_bound(), rand_bound());
        queue_request(CMD_NEXT, $urandom, 31'($urandom), rand_bound(), rand_bound());
        for (int k = CMD_SPARE_FIRST; k <= CMD_SPARE_LAST; k++)
            queue_request(3'(k), $urandom, 31'($urandom), rand_bound(), rand_bound());
        queue_request(CMD_READ, $urandom, 31'($urandom), rand_bound(), rand_bound());

        // random mix; every field carries noise whatever the command
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                c = CMD_NEXT;
            else if (r < 35)
                c = CMD_SEED;
            else if (r < 68)
                c = CMD_RANGED;
            else if (r < 78)
                c = CMD_RESTORE;
            else if (r < 93)
                c = CMD_READ;
            else
                c = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            sd = $urandom;
            if ($urandom_range(0, 3) == 0)
                sd = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 40))
                                                 : -32'($urandom_range(0, 40));
            rv = 31'($urandom);
            if ($urandom_range(0, 9) == 0)
                rv = ($urandom_range(0, 1) == 0) ? 31'd0 : LCG_MOD;
            queue_request(c, sd, rv, rand_bound(), rand_bound());
        end
        total_requests = pending_requests.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // every queued request must come back before the drain window
        while (responses_checked < total_requests)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_responses.size() != 0)
        begin
            $display("%0t: %0d responses never arrived", $time, expected_responses.size());
            error_count++;
        end

        $display("Run covered %0d requests (next %0d, seed %0d, ranged %0d,",
                 req_accepted, cmd_seen[CMD_NEXT], cmd_seen[CMD_SEED], cmd_seen[CMD_RANGED]);
        $display("  restore %0d, read %0d, spare codes %0d), %0d checked, %0d long hold-offs",
                 cmd_seen[CMD_RESTORE], cmd_seen[CMD_READ],
                 cmd_seen[CMD_SPARE_FIRST] + cmd_seen[CMD_SPARE_FIRST + 3'd1]
                 + cmd_seen[CMD_SPARE_LAST], responses_checked, holds_done);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("%0t: timeout with %0d responses outstanding", $time, expected_responses.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== minimal_standard_lcg_generator_top.f =====
rtl/core/mslcg_pkg.sv
rtl/core/minimal_standard_lcg_generator_top.sv
sim/minimal_standard_lcg_generator_top_tb.sv
